// ===== design/npcs_pkg.sv =====
// Shared constants, codes and control structs of the nearest palette color search.
`default_nettype none

package npcs_pkg;

   // Item field widths
   localparam int CMD_W         = 1;
   localparam int INDEX_W       = 8;
   localparam int ENTRY_COLOR_W = 32;
   localparam int COLOR_W       = 8;
   localparam int COUNT_W       = 9;
   localparam int RGB_W         = 3 * COLOR_W;

   // Channel offsets within a packed palette color
   localparam int RED_LSB   = 0;
   localparam int GREEN_LSB = 8;
   localparam int BLUE_LSB  = 16;

   // Squared RGB distance tops out at 3 * 255^2 = 195075
   localparam int DIST_W = 18;

   // Parameter defaults
   localparam int DEF_PALETTE_DEPTH = 256;
   localparam int DEF_SEARCH_LANES  = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   // Controller to datapath
   typedef struct packed {
      logic write_en;     // load one palette entry from the request word
      logic start_query;  // latch query target and count, clear running best
      logic issue;        // read the next palette row
      logic load_rsp;     // capture the final index into the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic query_empty;  // request word asks for zero entries
      logic last_row;     // the row being issued is the final one
      logic pipe_busy;    // a row is still in flight through the search pipeline
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/npcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module npcs_ram #(
   parameter int WIDTH = npcs_pkg::RGB_W,
   parameter int DEPTH = npcs_pkg::DEF_PALETTE_DEPTH,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/npcs_dpath.sv =====
// Datapath: palette lanes, per-lane distance units, lane reduction tree and running best.
`default_nettype none

module npcs_dpath #(
   parameter int PALETTE_DEPTH = npcs_pkg::DEF_PALETTE_DEPTH,
   parameter int SEARCH_LANES  = npcs_pkg::DEF_SEARCH_LANES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire npcs_pkg::ctrl_cmd_type                cmd,
   output npcs_pkg::dp_status_type                    status,
   input  wire logic [npcs_pkg::INDEX_W-1:0]          req_entry_index,
   input  wire logic [npcs_pkg::ENTRY_COLOR_W-1:0]    req_entry_color,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_red,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_green,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_blue,
   input  wire logic [npcs_pkg::COUNT_W-1:0]          req_entries_in_use,
   output logic      [npcs_pkg::INDEX_W-1:0]          rsp_match_index
);

   localparam int COLOR_W   = npcs_pkg::COLOR_W;
   localparam int RGB_W     = npcs_pkg::RGB_W;
   localparam int DIST_W    = npcs_pkg::DIST_W;
   localparam int INDEX_W   = npcs_pkg::INDEX_W;
   localparam int LANE_W    = (SEARCH_LANES > 1) ? $clog2(SEARCH_LANES) : 1;
   localparam int NUM_LANES = 1 << LANE_W;
   localparam int ROWS      = (PALETTE_DEPTH + NUM_LANES - 1) / NUM_LANES;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W     = ROW_W + LANE_W;
   localparam int NROW_W    = ROW_W + 1;
   localparam int DEPTH_W   = $clog2(PALETTE_DEPTH + 1);
   localparam int CNT_A     = (DEPTH_W > npcs_pkg::COUNT_W) ? DEPTH_W : npcs_pkg::COUNT_W;
   localparam int CNT_W     = (CNT_A > IDX_W + 1) ? CNT_A : IDX_W + 1;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // ---------------- write path ----------------
   logic [CNT_W-1:0]  wr_idx;
   logic              wr_ok;
   logic [ROW_W-1:0]  wr_row;
   logic [LANE_W-1:0] wr_lane;

   assign wr_idx  = CNT_W'(req_entry_index);
   assign wr_ok   = (wr_idx < CNT_W'(PALETTE_DEPTH));
   assign wr_row  = wr_idx[LANE_W +: ROW_W];
   assign wr_lane = wr_idx[LANE_W-1:0];

   // ---------------- query setup ----------------
   logic [CNT_W-1:0]  req_count;
   logic [CNT_W-1:0]  count_sat;
   logic [CNT_W:0]    rows_sum;
   logic [NROW_W-1:0] nrows_calc;

   assign req_count  = CNT_W'(req_entries_in_use);
   assign count_sat  = (req_count > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : req_count;
   assign rows_sum   = (CNT_W+1)'(count_sat) + (CNT_W+1)'(NUM_LANES - 1);
   assign nrows_calc = rows_sum[LANE_W +: NROW_W];

   logic [COLOR_W-1:0] tgt_red_ff,   tgt_red_in;
   logic [COLOR_W-1:0] tgt_green_ff, tgt_green_in;
   logic [COLOR_W-1:0] tgt_blue_ff,  tgt_blue_in;
   logic [CNT_W-1:0]   count_ff,     count_in;
   logic [NROW_W-1:0]  nrows_ff,     nrows_in;
   logic [ROW_W-1:0]   row_ff,       row_in;

   always_comb begin
      tgt_red_in   = tgt_red_ff;
      tgt_green_in = tgt_green_ff;
      tgt_blue_in  = tgt_blue_ff;
      count_in     = count_ff;
      nrows_in     = nrows_ff;
      row_in       = row_ff;
      if (cmd.start_query) begin
         tgt_red_in   = req_query_red;
         tgt_green_in = req_query_green;
         tgt_blue_in  = req_query_blue;
         count_in     = count_sat;
         nrows_in     = nrows_calc;
         row_in       = '0;
      end else if (cmd.issue) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      tgt_red_ff   <= tgt_red_in;
      tgt_green_ff <= tgt_green_in;
      tgt_blue_ff  <= tgt_blue_in;
      count_ff     <= count_in;
      nrows_ff     <= nrows_in;
      row_ff       <= row_in;
   end

   // ---------------- palette lanes ----------------
   logic [RGB_W-1:0] lane_color [NUM_LANES];

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_ram
      npcs_ram #(
         .WIDTH (RGB_W),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (cmd.write_en && wr_ok && (wr_lane == LANE_W'(l))),
         .wr_addr (wr_row),
         .wr_data (req_entry_color[RGB_W-1:0]),
         .rd_en   (cmd.issue),
         .rd_addr (row_ff),
         .rd_data (lane_color[l])
      );
   end

   logic             rd_valid_ff, rd_valid_in;
   logic [ROW_W-1:0] rd_row_ff,   rd_row_in;

   assign rd_valid_in = cmd.issue;
   assign rd_row_in   = row_ff;

   // ---------------- stage A: distance per lane ----------------
   logic [DIST_W-1:0]    a_dist_ff [NUM_LANES];
   logic [DIST_W-1:0]    a_dist_in [NUM_LANES];
   logic [NUM_LANES-1:0] a_ok_ff, a_ok_in;
   logic                 a_valid_ff, a_valid_in;
   logic [ROW_W-1:0]     a_row_ff,   a_row_in;

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_dist
      logic [COLOR_W-1:0]   dr, dg, db;
      logic [2*COLOR_W-1:0] sq_r, sq_g, sq_b;

      assign dr   = abs_diff(lane_color[l][npcs_pkg::RED_LSB   +: COLOR_W], tgt_red_ff);
      assign dg   = abs_diff(lane_color[l][npcs_pkg::GREEN_LSB +: COLOR_W], tgt_green_ff);
      assign db   = abs_diff(lane_color[l][npcs_pkg::BLUE_LSB  +: COLOR_W], tgt_blue_ff);
      assign sq_r = dr * dr;
      assign sq_g = dg * dg;
      assign sq_b = db * db;

      assign a_dist_in[l] = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
      // mask lanes past the requested count
      assign a_ok_in[l]   = (CNT_W'({rd_row_ff, LANE_W'(l)}) < count_ff);
   end

   assign a_valid_in = rd_valid_ff;
   assign a_row_in   = rd_row_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < NUM_LANES; l++) begin
         a_dist_ff[l] <= a_dist_in[l];
      end
      a_ok_ff  <= a_ok_in;
      a_row_ff <= a_row_in;
      rd_row_ff <= rd_row_in;
   end

   // ---------------- stage B: lane reduction tree ----------------
   logic [NUM_LANES-1:0] t_ok;
   logic [DIST_W-1:0]    t_dist [NUM_LANES];
   logic [LANE_W-1:0]    t_lane [NUM_LANES];

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         t_ok[i]   = a_ok_ff[i];
         t_dist[i] = a_dist_ff[i];
         t_lane[i] = LANE_W'(i);
      end
      // left holds the lower index; right wins if left is masked or strictly closer
      for (int lvl = 0; lvl < LANE_W; lvl++) begin
         for (int i = 0; i < NUM_LANES; i += (2 << lvl)) begin
            if (t_ok[i + (1 << lvl)] &&
                (!t_ok[i] || (t_dist[i + (1 << lvl)] < t_dist[i]))) begin
               t_ok[i]   = 1'b1;
               t_dist[i] = t_dist[i + (1 << lvl)];
               t_lane[i] = t_lane[i + (1 << lvl)];
            end
         end
      end
   end

   logic              b_valid_ff, b_valid_in;
   logic              b_ok_ff,    b_ok_in;
   logic [DIST_W-1:0] b_dist_ff,  b_dist_in;
   logic [IDX_W-1:0]  b_idx_ff,   b_idx_in;

   assign b_valid_in = a_valid_ff;
   assign b_ok_in    = t_ok[0];
   assign b_dist_in  = t_dist[0];
   assign b_idx_in   = {a_row_ff, t_lane[0]};

   always_ff @(posedge clock) begin
      b_ok_ff   <= b_ok_in;
      b_dist_ff <= b_dist_in;
      b_idx_ff  <= b_idx_in;
   end

   // ---------------- stage C: running best ----------------
   logic              best_ok_ff,   best_ok_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]  best_idx_ff,  best_idx_in;
   logic              best_upd;

   // earlier rows carry lower indexes, so a tie keeps the stored best
   assign best_upd = b_valid_ff && b_ok_ff && (!best_ok_ff || (b_dist_ff < best_dist_ff));

   always_comb begin
      best_ok_in   = best_ok_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (cmd.start_query) begin
         best_ok_in = 1'b0;
      end else if (best_upd) begin
         best_ok_in   = 1'b1;
         best_dist_in = b_dist_ff;
         best_idx_in  = b_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         best_ok_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         best_ok_ff  <= best_ok_in;
      end
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
   end

   // ---------------- response register ----------------
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   assign rsp_index_in = cmd.load_rsp ? (best_ok_ff ? INDEX_W'(best_idx_ff) : '0)
                                      : rsp_index_ff;

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_match_index = rsp_index_ff;

   // ---------------- status ----------------
   assign status.query_empty = (count_sat == '0);
   assign status.last_row    = ((NROW_W'(row_ff) + NROW_W'(1)) == nrows_ff);
   assign status.pipe_busy   = rd_valid_ff || a_valid_ff || b_valid_ff;

endmodule

`default_nettype wire

// ===== design/npcs_ctrl.sv =====
// Controller: request acceptance, row issue sequencing and response handshake.
`default_nettype none

module npcs_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [npcs_pkg::CMD_W-1:0]    req_cmd,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire npcs_pkg::dp_status_type       status,
   output npcs_pkg::ctrl_cmd_type             cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;
   logic      rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in         = state_ff;
      cmd.write_en     = 1'b0;
      cmd.start_query  = 1'b0;
      cmd.issue        = 1'b0;
      cmd.load_rsp     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_cmd == npcs_pkg::CMD_QUERY) begin
                  cmd.start_query = 1'b1;
                  state_in        = status.query_empty ? S_DRAIN : S_SCAN;
               end else begin
                  cmd.write_en = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_row) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy && rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_after_drain : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !status.pipe_busy)
      else $error("response loaded while a row is still in flight");

   a_query_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_cmd == npcs_pkg::CMD_QUERY)) |=>
         ((state_ff == S_SCAN) || (state_ff == S_DRAIN)))
      else $error("accepted query did not start a search");

   a_rsp_from_drain : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DRAIN))
      else $error("response raised outside the drain state");

endmodule

`default_nettype wire

// ===== design/nearest_palette_color_search_core.sv =====
// Top level of the nearest palette color search: controller plus palette datapath.
//
// Usage
//   Request channel (req_valid / req_stall): one word is either a palette write
//   (req_cmd = write) that loads req_entry_color[23:0] into slot req_entry_index,
//   or a query (req_cmd = query) that searches the first req_entries_in_use slots
//   (saturated to PALETTE_DEPTH) for the entry closest to the query color in
//   squared RGB distance. Ties go to the lowest index; an empty search answers 0.
//   Response channel (rsp_valid / rsp_stall): one word per query, none per write.
//   Timing: a query reads SEARCH_LANES (rounded up to a power of two) palette
//   entries per cycle from the lane memories, then drains through the read,
//   distance, reduction and merge registers before the answer is loaded into
//   the response register. The request side reopens in the cycle the answer
//   shows up, so a new word waits until the current query is answered. The lane
//   memory read port sets the pace: one row per cycle.
//   Reset clears control state only; palette contents stay undefined until written.
//   A stalled response holds in the output register; the block keeps accepting
//   words while it waits, and only a finished query blocks on a response still
//   not taken.
`default_nettype none

module nearest_palette_color_search_core #(
   parameter int PALETTE_DEPTH = npcs_pkg::DEF_PALETTE_DEPTH,
   parameter int SEARCH_LANES  = npcs_pkg::DEF_SEARCH_LANES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [npcs_pkg::CMD_W-1:0]            req_cmd,
   input  wire logic [npcs_pkg::INDEX_W-1:0]          req_entry_index,
   input  wire logic [npcs_pkg::ENTRY_COLOR_W-1:0]    req_entry_color,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_red,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_green,
   input  wire logic [npcs_pkg::COLOR_W-1:0]          req_query_blue,
   input  wire logic [npcs_pkg::COUNT_W-1:0]          req_entries_in_use,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [npcs_pkg::INDEX_W-1:0]          rsp_match_index
);

   // Command and status between the sequencer and the datapath
   npcs_pkg::ctrl_cmd_type  ctrl_cmd;
   npcs_pkg::dp_status_type dp_status;

   // Sequencer: accept words, step through palette rows, hand off the answer
   npcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Datapath: lane memories, distance units, reduction tree, running best
   npcs_dpath #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .SEARCH_LANES  (SEARCH_LANES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .req_entry_index    (req_entry_index),
      .req_entry_color    (req_entry_color),
      .req_query_red      (req_query_red),
      .req_query_green    (req_query_green),
      .req_query_blue     (req_query_blue),
      .req_entries_in_use (req_entries_in_use),
      .rsp_match_index    (rsp_match_index)
   );

endmodule

`default_nettype wire

// ===== dv/nearest_palette_color_search_core_tb.sv =====
// Self-checking testbench for the nearest palette color search core.
module nearest_palette_color_search_core_tb;

   localparam int DEPTH         = npcs_pkg::DEF_PALETTE_DEPTH;
   localparam int CMD_W         = npcs_pkg::CMD_W;
   localparam int INDEX_W       = npcs_pkg::INDEX_W;
   localparam int ENTRY_COLOR_W = npcs_pkg::ENTRY_COLOR_W;
   localparam int COLOR_W       = npcs_pkg::COLOR_W;
   localparam int COUNT_W       = npcs_pkg::COUNT_W;
   localparam int RGB_W         = npcs_pkg::RGB_W;
   localparam int RED_LSB       = npcs_pkg::RED_LSB;
   localparam int GREEN_LSB     = npcs_pkg::GREEN_LSB;
   localparam int BLUE_LSB      = npcs_pkg::BLUE_LSB;
   localparam int N_WORDS       = 1000;
   localparam int IDLE_LIMIT    = 3000;
   localparam int TAIL_WAIT     = 60;

   typedef struct {
      npcs_pkg::cmd_type         cmd;
      logic [INDEX_W-1:0]        index;
      logic [ENTRY_COLOR_W-1:0]  color;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
      logic [COUNT_W-1:0]        count;
      bit                        drain;   // hold this word until all answers are back
   } palette_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid          = 1'b0;
   logic                      req_stall;
   logic [CMD_W-1:0]          req_cmd            = '0;
   logic [INDEX_W-1:0]        req_entry_index    = '0;
   logic [ENTRY_COLOR_W-1:0]  req_entry_color    = '0;
   logic [COLOR_W-1:0]        req_query_red      = '0;
   logic [COLOR_W-1:0]        req_query_green    = '0;
   logic [COLOR_W-1:0]        req_query_blue     = '0;
   logic [COUNT_W-1:0]        req_entries_in_use = '0;
   logic                      rsp_valid;
   logic                      rsp_stall          = 1'b0;
   logic [INDEX_W-1:0]        rsp_match_index;

   palette_request_type pending_words[$];
   palette_request_type cur_word;
   logic [INDEX_W-1:0]  expected_index_q[$];
   logic [RGB_W-1:0]    palette_model [DEPTH];   // predictor copy, updated on accept
   logic [RGB_W-1:0]    shadow_palette [DEPTH];  // generator copy, updated on push
   int                  n_accepted  = 0;
   int                  n_words     = 0;
   int                  n_errors    = 0;
   int                  idle_cycles = 0;

   nearest_palette_color_search_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_entry_color    (req_entry_color),
      .req_query_red      (req_query_red),
      .req_query_green    (req_query_green),
      .req_query_blue     (req_query_blue),
      .req_entries_in_use (req_entries_in_use),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_index    (rsp_match_index)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      n_errors++;
   endtask

   // Idle percentage per side: sender light / receiver heavy, then swapped, then none.
   function automatic int idle_pct(input bit sender, input int done);
      if (done < n_words / 3)
         return sender ? 14 : 78;
      else if (done < 2 * n_words / 3)
         return sender ? 78 : 14;
      return 0;
   endfunction

   // Lowest index of the least squared RGB distance among the leading entries.
   function automatic logic [INDEX_W-1:0] nearest_index(input logic [COLOR_W-1:0] r,
                                                        input logic [COLOR_W-1:0] g,
                                                        input logic [COLOR_W-1:0] b,
                                                        input logic [COUNT_W-1:0] count);
      int          n;
      int          dr;
      int          dg;
      int          db;
      int unsigned sq_dist;
      int unsigned best_dist;
      int          best;
      n         = (count > DEPTH) ? DEPTH : int'(count);
      best_dist = 32'hFFFF_FFFF;
      best      = 0;
      for (int i = 0; i < n; i++) begin
         dr      = int'(palette_model[i][RED_LSB   +: COLOR_W]) - int'(r);
         dg      = int'(palette_model[i][GREEN_LSB +: COLOR_W]) - int'(g);
         db      = int'(palette_model[i][BLUE_LSB  +: COLOR_W]) - int'(b);
         sq_dist = dr * dr + dg * dg + db * db;
         if (sq_dist < best_dist) begin
            best_dist = sq_dist;
            best      = i;
         end
      end
      return best[INDEX_W-1:0];
   endfunction

   task automatic push_write(input int slot, input logic [ENTRY_COLOR_W-1:0] color);
      palette_request_type w;
      w.cmd   = npcs_pkg::CMD_WRITE;
      w.index = INDEX_W'(slot);
      w.color = color;
      w.red   = COLOR_W'($urandom);
      w.green = COLOR_W'($urandom);
      w.blue  = COLOR_W'($urandom);
      w.count = COUNT_W'($urandom);
      w.drain = 1'b0;
      pending_words.push_back(w);
      shadow_palette[slot] = color[RGB_W-1:0];
   endtask

   task automatic push_query(input int r, input int g, input int b, input int count);
      palette_request_type w;
      w.cmd   = npcs_pkg::CMD_QUERY;
      w.index = INDEX_W'($urandom);
      w.color = $urandom;
      w.red   = COLOR_W'(r);
      w.green = COLOR_W'(g);
      w.blue  = COLOR_W'(b);
      w.count = COUNT_W'(count);
      w.drain = 1'b0;
      pending_words.push_back(w);
   endtask

   // Query near an existing palette color, so exact hits and ties show up often.
   task automatic push_query_near(input int slot, input int count);
      logic [RGB_W-1:0] c;
      c = shadow_palette[slot];
      push_query(c[RED_LSB +: COLOR_W], c[GREEN_LSB +: COLOR_W], c[BLUE_LSB +: COLOR_W],
                 count);
   endtask

   // Stimulus and end of run.
   initial begin
      int post_fill;
      int slot;
      int count;

      // Directed: primaries, extremes, duplicate colors for ties, alpha set on some.
      push_write(0, 32'hFF00_0000);
      push_write(1, 32'h00FF_FFFF);
      push_write(2, 32'hAB00_00FF);
      push_write(3, 32'h0000_FF00);
      push_write(4, 32'h00FF_0000);
      push_write(5, 32'h5500_FFFF);
      push_write(6, 32'h00FF_FFFF);
      push_write(7, 32'h1200_0000);
      push_query(8'hFF, 8'hFF, 8'hFF, 0);   // empty search
      push_query(8'hFF, 8'hFF, 8'hFF, 1);
      push_query(8'hFF, 8'hFF, 8'hFF, 8);   // white tie: lower slot wins
      push_query(8'h00, 8'h00, 8'h00, 8);   // black tie
      push_query(8'hFF, 8'h00, 8'h00, 8);
      push_query(8'h00, 8'hFF, 8'h00, 8);
      push_query(8'h00, 8'h00, 8'hFF, 8);
      push_query(8'hFF, 8'hFF, 8'h00, 8);
      push_query(8'h80, 8'h80, 8'h80, 7);
      push_query(8'h00, 8'h00, 8'h00, 1);

      // Fill the rest of the palette in order; query only the written prefix.
      for (int i = 8; i < DEPTH; i++) begin
         if ($urandom_range(3) == 0)
            push_query($urandom, $urandom, $urandom, $urandom_range(i, 0));
         if ($urandom_range(7) == 0)
            push_write(i, {8'($urandom_range(255, 0)),
                           shadow_palette[$urandom_range(i - 1, 0)]});
         else
            push_write(i, $urandom);
      end

      // Whole palette is valid now: every count is fair game, saturation included.
      post_fill = pending_words.size();
      push_query($urandom, $urandom, $urandom, 9'h1FF);
      push_query_near($urandom_range(DEPTH - 1, 0), DEPTH);

      while (pending_words.size() < N_WORDS) begin
         if ($urandom_range(99) < 55) begin
            case ($urandom_range(4))
               0:       count = $urandom_range(511, 0);
               1:       count = $urandom_range(511, DEPTH);
               default: count = $urandom_range(40, 0);
            endcase
            if ($urandom_range(2) == 0)
               push_query_near($urandom_range(DEPTH - 1, 0), count);
            else
               push_query($urandom, $urandom, $urandom, count);
         end else begin
            slot = $urandom_range(DEPTH - 1, 0);
            case ($urandom_range(7))
               0:       push_write(slot, {8'($urandom), 24'h00_0000});
               1:       push_write(slot, {8'($urandom), 24'hFF_FFFF});
               2, 3:    push_write(slot, {8'($urandom),
                                           shadow_palette[$urandom_range(DEPTH - 1, 0)]});
               default: push_write(slot, $urandom);
            endcase
         end
      end

      // Let the search drain before the first full-palette query and at phase changes.
      n_words = pending_words.size();
      pending_words[post_fill].drain       = 1'b1;
      pending_words[n_words / 3].drain     = 1'b1;
      pending_words[2 * n_words / 3].drain = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_index_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Driver: present one word at a time, hold it while stalled.
   always @(posedge clock) begin
      logic give;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         give = 1'b0;
         if (req_valid && !req_stall) begin
            // Word taken: update the palette copy or predict the answer.
            if (cur_word.cmd == npcs_pkg::CMD_WRITE) begin
               if (cur_word.index < DEPTH)
                  palette_model[cur_word.index] = cur_word.color[RGB_W-1:0];
            end else begin
               expected_index_q.push_back(nearest_index(cur_word.red, cur_word.green,
                                                        cur_word.blue, cur_word.count));
            end
            n_accepted <= n_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct(1, n_accepted)
                && (!pending_words[0].drain || expected_index_q.size() == 0)) begin
               cur_word = pending_words.pop_front();
               give     = 1'b1;
               req_cmd            <= cur_word.cmd;
               req_entry_index    <= cur_word.index;
               req_entry_color    <= cur_word.color;
               req_query_red      <= cur_word.red;
               req_query_green    <= cur_word.green;
               req_query_blue     <= cur_word.blue;
               req_entries_in_use <= cur_word.count;
            end
            req_valid <= give;
         end
      end
   end

   // Monitor: compare each taken answer with the oldest prediction.
   always @(posedge clock) begin
      logic [INDEX_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_index_q.size() == 0) begin
               report_mismatch($sformatf("answer %0d with no query waiting",
                                         rsp_match_index));
            end else begin
               want = expected_index_q.pop_front();
               if (rsp_match_index !== want)
                  report_mismatch($sformatf("match index got %0d, want %0d",
                                            rsp_match_index, want));
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct(0, n_accepted));
      end
   end

   // Watchdog: end the run if no word moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
